@@ src/gf2irr_pkg.sv @@
// package with shared constants and types for the gf2 irreducibility test
`timescale 1ns / 1ps
`default_nettype none
package gf2irr_pkg;
    localparam int MAX_DEGREE = 63;
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam logic [ROW_W-1:0] ODD_COEF_MASK = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GCD,
        ST_BUILD,
        ST_SRD,
        ST_SEV,
        ST_SWP,
        ST_ERD,
        ST_EEV,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

@@ src/gf2_poly_irreducibility_test.sv @@
// top level: berlekamp irreducibility test with the matrix rows held in a memory
// sequence: input checks, the gcd reduction steps, building the rows, then for each column
// a pivot search and an elimination sweep over the rows held in the memory
// throughput: one polynomial at a time, set by the row memory sweeps
// reset: rst_n asynchronous active low clears the sequencer and the output valid flag
`timescale 1ns / 1ps
`default_nettype none
module gf2_poly_irreducibility_test
    import gf2irr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // poly [63:0], degree [69:64], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // irreducible [0], zero pad
);
    state_t state_reg, state_next;

    logic [ROW_W-1:0] f_reg, f_next, a_reg, a_next, b_reg, b_next;
    logic [ROW_W-1:0] r_reg, r_next, piv_row_reg, piv_row_next, first_reg, first_next;
    logic [IDX_W-1:0] n_reg, n_next, da_reg, da_next, db_reg, db_next;
    logic [IDX_W-1:0] j_reg, j_next, col_reg, col_next, rank_reg, rank_next;
    logic [IDX_W-1:0] piv_reg, piv_next;
    logic             res_reg, res_next;
    logic             ovalid_reg, ovalid_next, obit_reg, obit_next;

    // row memory
    logic [ROW_W-1:0] mem [0:MAX_DEGREE];
    logic [ROW_W-1:0] rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic [ROW_W-1:0] in_poly;
    logic [IDX_W-1:0] in_deg;
    logic             in_ok;
    logic [ROW_W-1:0] r_one, r_two;
    logic             j_last;

    assign in_poly = s_tdata[63:0];
    assign in_deg  = s_tdata[69:64];
    assign in_ok   = (in_deg != '0) && ((in_poly >> in_deg) == 64'd1);
    assign j_last  = ({1'b0, j_reg} + 7'd1) == {1'b0, n_reg};

    // two doubling steps of x^(2i) mod f
    always_comb
    begin
        r_one = r_reg << 1;
        if (r_one[n_reg])
        begin
            r_one = r_one ^ f_reg;
        end
        r_two = r_one << 1;
        if (r_two[n_reg])
        begin
            r_two = r_two ^ f_reg;
        end
    end

    // handshake outputs
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, obit_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_ok && ((in_poly & ODD_COEF_MASK) != '0))
                        state_next = ST_GCD;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_GCD:
            begin
                if (!b_reg[db_reg] && db_reg == '0)
                    state_next = (a_reg == 64'd1) ? ST_BUILD : ST_DONE;
            end
            ST_BUILD:
            begin
                if (j_last)
                    state_next = ST_SRD;
            end
            ST_SRD:
                state_next = ST_SEV;
            ST_SEV:
            begin
                if (rdata_reg[col_reg])
                    state_next = ST_SWP;
                else if (!j_last)
                    state_next = ST_SRD;
                else if (({1'b0, col_reg} + 7'd1) == {1'b0, n_reg})
                    state_next = ST_DONE;
                else
                    state_next = ST_SRD;
            end
            ST_SWP:
            begin
                if (({1'b0, piv_reg} + 7'd1) != {1'b0, n_reg})
                    state_next = ST_ERD;
                else if (({1'b0, col_reg} + 7'd1) == {1'b0, n_reg} ||
                         ({1'b0, rank_reg} + 7'd1) == {1'b0, n_reg})
                    state_next = ST_DONE;
                else
                    state_next = ST_SRD;
            end
            ST_ERD:
                state_next = ST_EEV;
            ST_EEV:
            begin
                if (!j_last)
                    state_next = ST_ERD;
                else if (({1'b0, col_reg} + 7'd1) == {1'b0, n_reg} || rank_reg == n_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_SRD;
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        f_next       = f_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        r_next       = r_reg;
        piv_row_next = piv_row_reg;
        first_next   = first_reg;
        n_next       = n_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        j_next       = j_reg;
        col_next     = col_reg;
        rank_next    = rank_reg;
        piv_next     = piv_reg;
        res_next     = res_reg;
        ovalid_next  = ovalid_reg;
        obit_next    = obit_reg;
        mem_we       = 1'b0;
        mem_waddr    = j_reg;
        mem_wdata    = rdata_reg;

        // result register frees on transfer
        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                f_next   = in_poly;
                n_next   = in_deg;
                a_next   = in_poly;
                b_next   = (in_poly & ODD_COEF_MASK) >> 1;
                da_next  = in_deg;
                db_next  = in_deg - 6'd1;
                res_next = 1'b0;
            end
            ST_GCD:
            begin
                if (!b_reg[db_reg])
                begin
                    if (db_reg != '0)
                        db_next = db_reg - 6'd1;
                    else
                    begin
                        // gcd found, set up row build
                        r_next = 64'd1;
                        j_next = '0;
                    end
                end
                else if (!a_reg[da_reg] && da_reg != '0)
                    da_next = da_reg - 6'd1;
                else if (a_reg[da_reg] && da_reg >= db_reg)
                    a_next = a_reg ^ (b_reg << (da_reg - db_reg));
                else
                begin
                    a_next  = b_reg;
                    b_next  = a_reg;
                    da_next = db_reg;
                    db_next = da_reg;
                end
            end
            ST_BUILD:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = r_reg ^ (64'd1 << j_reg);
                r_next    = r_two;
                j_next    = j_last ? '0 : j_reg + 6'd1;
                col_next  = '0;
                rank_next = '0;
                // a single zero row already has rank degree - 1
                res_next  = (n_reg == 6'd1);
            end
            ST_SEV:
            begin
                if (j_reg == rank_reg)
                    first_next = rdata_reg;
                if (rdata_reg[col_reg])
                begin
                    // pivot found: old rank row goes to the pivot slot
                    piv_next     = j_reg;
                    piv_row_next = rdata_reg;
                    mem_we       = 1'b1;
                    mem_waddr    = j_reg;
                    mem_wdata    = (j_reg == rank_reg) ? rdata_reg : first_reg;
                end
                else if (!j_last)
                    j_next = j_reg + 6'd1;
                else
                begin
                    col_next = col_reg + 6'd1;
                    j_next   = rank_reg;
                end
            end
            ST_SWP:
            begin
                mem_we    = 1'b1;
                mem_waddr = rank_reg;
                mem_wdata = piv_row_reg;
                rank_next = rank_reg + 6'd1;
                res_next  = ({1'b0, rank_reg} + 7'd2) == {1'b0, n_reg};
                if (({1'b0, piv_reg} + 7'd1) != {1'b0, n_reg})
                    j_next = piv_reg + 6'd1;
                else
                begin
                    col_next = col_reg + 6'd1;
                    j_next   = rank_reg + 6'd1;
                end
            end
            ST_EEV:
            begin
                if (rdata_reg[col_reg])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = j_reg;
                    mem_wdata = rdata_reg ^ piv_row_reg;
                end
                if (!j_last)
                    j_next = j_reg + 6'd1;
                else
                begin
                    col_next = col_reg + 6'd1;
                    j_next   = rank_reg;
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    obit_next   = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // row memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[j_reg];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        f_reg       <= f_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        r_reg       <= r_next;
        piv_row_reg <= piv_row_next;
        first_reg   <= first_next;
        n_reg       <= n_next;
        da_reg      <= da_next;
        db_reg      <= db_next;
        j_reg       <= j_next;
        col_reg     <= col_next;
        rank_reg    <= rank_next;
        piv_reg     <= piv_next;
        res_reg     <= res_next;
        obit_reg    <= obit_next;
    end

    // rank never runs ahead of the column under pivot search
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEV) |-> rank_reg <= col_reg)
        else $error("rank ahead of column");

    // row index stays inside the matrix while sweeping
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEV || state_reg == ST_EEV || state_reg == ST_BUILD)
        |-> j_reg < n_reg)
        else $error("row index beyond degree");

    // a result is loaded only on leaving the done state
    assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(ovalid_reg) && ovalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside done state");
endmodule
`default_nettype wire

@@ verif/gf2_poly_irreducibility_test_tb.sv @@
// testbench for the gf2 polynomial irreducibility test: random and directed polynomials
`timescale 1ns / 1ps
`default_nettype none
module gf2_poly_irreducibility_test_tb;
    import gf2irr_pkg::*;

    typedef struct packed {
        logic [5:0]  degree;
        logic [63:0] poly;
    } poly_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // poly [63:0], degree [69:64], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // irreducible [0], zero pad

    poly_item_t pending_polys[$];
    logic       expected_verdicts[$];
    int         fail_count;
    bit         stimulus_done;
    int         burst_left;
    int         gap_left;
    int         stall_phase;
    logic       in_taken;

    gf2_poly_irreducibility_test i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned top_index(logic [63:0] p);
        int unsigned d;
        d = 0;
        for (int b = 1; b < 64; b++)
            if (p[b])
                d = b;
        return d;
    endfunction

    // remainder over gf2, divisor nonzero
    function automatic logic [63:0] gf2_rem(logic [63:0] a, logic [63:0] b);
        int unsigned db;
        int unsigned da;
        db = top_index(b);
        while (a != 0)
        begin
            da = top_index(a);
            if (da < db)
                break;
            a = a ^ (b << (da - db));
        end
        return a;
    endfunction

    function automatic logic [63:0] gf2_gcd(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0)
        begin
            r = gf2_rem(a, b);
            a = b;
            b = r;
        end
        return a;
    endfunction

    // rank of the berlekamp matrix must be degree - 1
    function automatic bit berlekamp_rank_ok(logic [63:0] f, int unsigned n);
        logic [63:0] rows[64];
        logic [63:0] r;
        logic [63:0] t;
        int unsigned rank;
        int unsigned piv;
        r = 64'd1;
        for (int unsigned i = 0; i < n; i++)
        begin
            rows[i] = r ^ (64'd1 << i);
            for (int s = 0; s < 2; s++)
            begin
                r = r << 1;
                if (r[n])
                    r = r ^ f;
            end
        end
        rank = 0;
        for (int unsigned col = 0; col < n && rank < n; col++)
        begin
            piv = n;
            for (int unsigned j = rank; j < n; j++)
                if (rows[j][col])
                begin
                    piv = j;
                    break;
                end
            if (piv == n)
                continue;
            t = rows[piv];
            rows[piv] = rows[rank];
            rows[rank] = t;
            for (int unsigned j = rank + 1; j < n; j++)
                if (rows[j][col])
                    rows[j] = rows[j] ^ rows[rank];
            rank++;
        end
        return (rank + 1 == n);
    endfunction

    function automatic logic predict_irreducible(poly_item_t it);
        logic [63:0] d;
        int unsigned n;
        n = it.degree;
        if (it.poly == 0 || n < 1 || n > MAX_DEGREE || top_index(it.poly) != n)
            return 1'b0;
        d = (it.poly & ODD_COEF_MASK) >> 1;
        if (d == 0 || gf2_gcd(it.poly, d) != 64'd1)
            return 1'b0;
        return berlekamp_rank_ok(it.poly, n);
    endfunction

    task automatic add_poly(logic [63:0] p, logic [5:0] n);
        poly_item_t it;
        it.poly = p;
        it.degree = n;
        pending_polys.push_back(it);
    endtask

    // random polynomial of given degree, well formed
    function automatic logic [63:0] rand_poly(int unsigned n);
        logic [63:0] p;
        p = {$urandom, $urandom};
        if (n < 63)
            p = p & ((64'd1 << (n + 1)) - 1);
        p[n] = 1'b1;
        if ($urandom_range(0, 3) != 0)
            p[0] = 1'b1;
        return p;
    endfunction

    // stimulus
    initial
    begin
        int unsigned n;
        logic [63:0] p;
        add_poly(64'd0, 6'd0);
        add_poly(64'd1, 6'd0);
        add_poly(64'd2, 6'd1);
        add_poly(64'd3, 6'd1);
        add_poly(64'h7, 6'd2);
        add_poly(64'hB, 6'd3);
        add_poly(64'hD, 6'd3);
        add_poly(64'h13, 6'd4);
        add_poly(64'h1F, 6'd4);
        add_poly(64'h5, 6'd2);
        add_poly(64'h11, 6'd4);
        add_poly(64'h15, 6'd4);
        add_poly(64'h8000_0000_0000_0003, 6'd63);
        add_poly(64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        add_poly(64'hFFFF_FFFF_FFFF_FFFF, 6'd62);
        add_poly(64'h8000_0000_0000_0000, 6'd63);
        add_poly(64'h4000_0000_0000_0003, 6'd62);
        add_poly(64'h13, 6'd5);
        add_poly(64'h0, 6'd63);
        add_poly(64'hAAAA_AAAA_AAAA_AAAA, 6'd63);
        add_poly(64'h5555_5555_5555_5555, 6'd62);
        for (int k = 0; k < 120; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_poly({$urandom, $urandom}, 6'($urandom));
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(40, 63);
                else
                    n = $urandom_range(1, 16);
                p = rand_poly(n);
                add_poly(p, 6'(n));
            end
        end
        stimulus_done = 1'b1;
    end

    // reset and input defaults
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        fail_count = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // input transfer seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_tvalid && s_tready;
    end

    // driver: bursts of transfers with random gaps
    always @(negedge clk)
    begin
        poly_item_t it;
        if (rst_n)
        begin
            if (in_taken)
            begin
                it = pending_polys.pop_front();
                expected_verdicts.push_back(predict_irreducible(it));
                if (burst_left > 0)
                    burst_left--;
            end
            if (!(s_tvalid && !in_taken))
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 6);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_polys.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {2'b00, pending_polys[0].degree, pending_polys[0].poly};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: stretches ready, stretches mostly stalled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase = (stall_phase + 1) % 64;
            if (stall_phase < 24)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 2) == 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        logic want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("irreducible: result with no expectation, actual %0d", m_tdata[0]);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_tdata[0] !== want)
                begin
                    $error("irreducible: expected %0d actual %0d", want, m_tdata[0]);
                    fail_count++;
                end
            end
        end
    end

    // end of run
    initial
    begin
        wait (stimulus_done);
        wait (rst_n);
        while (pending_polys.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
src/gf2irr_pkg.sv
src/gf2_poly_irreducibility_test.sv
verif/gf2_poly_irreducibility_test_tb.sv
